// ===== rtl/aec_pkg.sv =====
// Shared types, widths and constants of the arithmetic encoder.
`timescale 1ns / 1ps

package aec_pkg;

    // Defaults of the top-level parameters
    localparam int SYMBOLS_DEFAULT       = 16;
    localparam int PROB_BITS_DEFAULT     = 16;
    localparam int MIN_CODE_BITS_DEFAULT = 32;

    // Field widths
    localparam int OP_W       = 2;
    localparam int SYM_W      = 4;
    localparam int BOUNDARY_W = 17;
    localparam int CODE_W     = 32;
    localparam int COUNT_W    = 6;
    localparam int LOW_W      = 32;
    localparam int HIGH_W     = 33;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    // Interval constants, one is 2^32
    localparam logic [HIGH_W-1:0]  ONE_INTERVAL  = 33'h1_0000_0000;
    localparam logic [HIGH_W-1:0]  HALF_INTERVAL = 33'h0_8000_0000;
    localparam logic [HIGH_W:0]    MIN_WIDTH     = 34'd65536;
    localparam logic [COUNT_W-1:0] MAX_OUT_BITS  = 6'd32;

    // Operation codes carried on s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_MUL,
        ST_SUM,
        ST_SCALE,
        ST_DONE
    } state_t;

    // Outcome of a rescale run
    typedef struct packed {
        logic [LOW_W-1:0]   low;
        logic [HIGH_W-1:0]  high;
        logic [CODE_W-1:0]  code;
        logic [COUNT_W-1:0] count;
    } rescale_res_t;

endpackage

// ===== rtl/arithmetic_encoder_e1e2.sv =====
// Encode: the bit-serial interval multiply (PROB_BITS + 1 steps) runs first, then the one-bit
// rescale loop, which emits up to 32 bits. Load, flush and out-of-range items skip both;
// an empty or collapsed interval is refused after the multiply, before any rescale.
// One item is in work at a time; the next transfer is taken while a finished result still
// waits in the output register.
// Reset (aresetn low, synchronous): interval [0, 1), bit count zero, no result; table kept.
`timescale 1ns / 1ps

module arithmetic_encoder_e1e2 #(
    parameter int SYMBOLS       = aec_pkg::SYMBOLS_DEFAULT,
    parameter int PROB_BITS     = aec_pkg::PROB_BITS_DEFAULT,
    parameter int MIN_CODE_BITS = aec_pkg::MIN_CODE_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aec_pkg::S_TDATA_W-1:0]   s_tdata,  // symbol[3:0], boundary[20:4], zero pad
    input  logic [aec_pkg::OP_W-1:0]        s_tuser,  // op[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [aec_pkg::M_TDATA_W-1:0]   m_tdata,  // code_bits[31:0], bit_count[37:32], pad
    output logic                            m_tuser   // error
);

    localparam int IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int CW    = PROB_BITS + 1;
    localparam logic [24:0] ONE_CUM = 25'(1) << PROB_BITS;

    logic                             s_accept;
    aec_pkg::op_t                     s_op;
    logic [aec_pkg::SYM_W-1:0]        s_sym;
    logic [aec_pkg::BOUNDARY_W-1:0]   s_boundary;
    logic                             s_sym_ok;

    aec_pkg::state_t                  state_reg, state_next;
    logic [aec_pkg::LOW_W-1:0]        low_reg, low_next;
    logic [aec_pkg::HIGH_W-1:0]       high_reg, high_next;
    logic [aec_pkg::COUNT_W-1:0]      bits_sent_reg, bits_sent_next;
    logic [aec_pkg::SYM_W-1:0]        sym_reg, sym_next;
    logic [CW-1:0]                    c_hi_reg, c_hi_next;
    logic                             empty_reg, empty_next;
    logic [aec_pkg::CODE_W-1:0]       res_code_reg, res_code_next;
    logic [aec_pkg::COUNT_W-1:0]      res_count_reg, res_count_next;
    logic                             res_err_reg, res_err_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [aec_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                             m_tuser_reg, m_tuser_next;

    logic                             ram_we;
    logic [IDX_W-1:0]                 ram_waddr;
    logic [IDX_W-1:0]                 ram_raddr;
    logic [aec_pkg::BOUNDARY_W-1:0]   ram_rdata;
    logic [7:0]                       sym_prev;

    logic [CW-1:0]                    c_rd;
    logic [CW-1:0]                    c_lo;
    logic                             mul_start;
    logic [aec_pkg::HIGH_W-1:0]       width_cur;
    logic                             mul_done_hi;
    logic                             mul_done_lo;
    logic [aec_pkg::HIGH_W-1:0]       prod_hi;
    logic [aec_pkg::HIGH_W-1:0]       prod_lo;

    logic [aec_pkg::HIGH_W-1:0]       new_lo;
    logic [aec_pkg::HIGH_W-1:0]       new_hi;
    logic [aec_pkg::HIGH_W:0]         new_width;
    logic                             collapsed;
    logic                             scale_start;
    logic                             scale_done;
    aec_pkg::rescale_res_t            scale_res;
    logic [6:0]                       bits_sum;

    logic [6:0]                       flush_have;
    logic [6:0]                       flush_diff;
    logic [aec_pkg::COUNT_W-1:0]      flush_n;
    logic [aec_pkg::CODE_W-1:0]       flush_code;

    // Unpack the input transfer
    assign s_accept   = s_tvalid && s_tready;
    assign s_op       = aec_pkg::op_t'(s_tuser);
    assign s_sym      = s_tdata[aec_pkg::SYM_W-1:0];
    assign s_boundary = s_tdata[aec_pkg::SYM_W +: aec_pkg::BOUNDARY_W];
    assign s_sym_ok   = 9'(s_sym) < 9'(SYMBOLS);
    assign s_tready   = (state_reg == aec_pkg::ST_IDLE);

    // Cumulative table
    assign ram_we    = s_accept && (s_op == aec_pkg::OP_LOAD) && s_sym_ok;
    assign ram_waddr = IDX_W'(8'(s_sym));
    assign sym_prev  = 8'(sym_reg) - 8'd1;
    assign ram_raddr = (state_reg == aec_pkg::ST_IDLE) ? IDX_W'(8'(s_sym)) : IDX_W'(sym_prev);

    aec_ram #(
        .WIDTH (aec_pkg::BOUNDARY_W),
        .DEPTH (SYMBOLS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_boundary),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Saturate a table word to one
    assign c_rd = (25'(ram_rdata) > ONE_CUM) ? CW'(ONE_CUM) : CW'(25'(ram_rdata));
    assign c_lo = (sym_reg == '0) ? '0 : c_rd;

    // Both interval products run side by side
    assign mul_start = (state_reg == aec_pkg::ST_FETCH_LO);
    assign width_cur = high_reg - {1'b0, low_reg};

    aec_mul #(
        .PROB_BITS (PROB_BITS)
    ) u_mul_hi (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mul_start),
        .width_in  (width_cur),
        .factor_in (c_hi_reg),
        .done      (mul_done_hi),
        .product   (prod_hi)
    );

    aec_mul #(
        .PROB_BITS (PROB_BITS)
    ) u_mul_lo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mul_start),
        .width_in  (width_cur),
        .factor_in (c_lo),
        .done      (mul_done_lo),
        .product   (prod_lo)
    );

    // Narrowed interval and collapse check
    assign new_lo      = {1'b0, low_reg} + prod_lo;
    assign new_hi      = {1'b0, low_reg} + prod_hi;
    assign new_width   = {1'b0, prod_hi} - {1'b0, prod_lo};
    assign collapsed   = empty_reg || (new_width < aec_pkg::MIN_WIDTH);
    assign scale_start = (state_reg == aec_pkg::ST_SUM) && !collapsed;

    aec_rescale u_rescale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scale_start),
        .lo_in   (new_lo),
        .hi_in   (new_hi),
        .done    (scale_done),
        .res     (scale_res)
    );

    assign bits_sum = 7'(bits_sent_reg) + 7'(scale_res.count);

    // Flush length: reach the minimum code length, at least one bit, at most a word
    assign flush_have = 7'(bits_sent_reg);
    assign flush_diff = 7'(MIN_CODE_BITS) - flush_have;
    always_comb begin
        if (flush_have >= 7'(MIN_CODE_BITS)) begin
            flush_n = 6'd1;
        end else if (flush_diff > 7'(aec_pkg::MAX_OUT_BITS)) begin
            flush_n = aec_pkg::MAX_OUT_BITS;
        end else begin
            flush_n = 6'(flush_diff);
        end
        flush_code = aec_pkg::CODE_W'(1) << 5'(flush_n - 6'd1);
    end

    // Sequencer: next state and register updates
    always_comb begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        bits_sent_next = bits_sent_reg;
        sym_next       = sym_reg;
        c_hi_next      = c_hi_reg;
        empty_next     = empty_reg;
        res_code_next  = res_code_reg;
        res_count_next = res_count_reg;
        res_err_next   = res_err_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;

        // Drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            aec_pkg::ST_IDLE: begin
                if (s_accept) begin
                    sym_next       = s_sym;
                    res_code_next  = '0;
                    res_count_next = '0;
                    res_err_next   = 1'b0;
                    state_next     = aec_pkg::ST_DONE;
                    unique case (s_op)
                        aec_pkg::OP_LOAD: begin
                        end
                        aec_pkg::OP_ENCODE: begin
                            if (s_sym_ok) begin
                                state_next = aec_pkg::ST_FETCH_HI;
                            end else begin
                                res_err_next = 1'b1;
                            end
                        end
                        aec_pkg::OP_FLUSH: begin
                            res_code_next  = flush_code;
                            res_count_next = flush_n;
                            low_next       = '0;
                            high_next      = aec_pkg::ONE_INTERVAL;
                            bits_sent_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            aec_pkg::ST_FETCH_HI: begin
                c_hi_next  = c_rd;
                state_next = aec_pkg::ST_FETCH_LO;
            end
            aec_pkg::ST_FETCH_LO: begin
                empty_next = (c_hi_reg <= c_lo);
                state_next = aec_pkg::ST_MUL;
            end
            aec_pkg::ST_MUL: begin
                if (mul_done_hi && mul_done_lo) begin
                    state_next = aec_pkg::ST_SUM;
                end
            end
            aec_pkg::ST_SUM: begin
                if (collapsed) begin
                    res_err_next = 1'b1;
                    state_next   = aec_pkg::ST_DONE;
                end else begin
                    state_next = aec_pkg::ST_SCALE;
                end
            end
            aec_pkg::ST_SCALE: begin
                if (scale_done) begin
                    low_next       = scale_res.low;
                    high_next      = scale_res.high;
                    bits_sent_next = (bits_sum > 7'(aec_pkg::MAX_OUT_BITS)) ?
                                     aec_pkg::MAX_OUT_BITS : 6'(bits_sum);
                    res_code_next  = scale_res.code;
                    res_count_next = scale_res.count;
                    state_next     = aec_pkg::ST_DONE;
                end
            end
            aec_pkg::ST_DONE: begin
                // Hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = aec_pkg::M_TDATA_W'({res_count_reg, res_code_reg});
                    m_tuser_next  = res_err_reg;
                    state_next    = aec_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = aec_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= aec_pkg::ST_IDLE;
            low_reg       <= '0;
            high_reg      <= aec_pkg::ONE_INTERVAL;
            bits_sent_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            bits_sent_reg <= bits_sent_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        sym_reg       <= sym_next;
        c_hi_reg      <= c_hi_next;
        empty_reg     <= empty_next;
        res_code_reg  <= res_code_next;
        res_count_reg <= res_count_next;
        res_err_reg   <= res_err_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/aec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module aec_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, register the read word
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/aec_mul.sv =====
// Bit-serial scaling multiplier: floor(width * factor / 2^PROB_BITS), one factor bit per cycle.
`timescale 1ns / 1ps

module aec_mul #(
    parameter int PROB_BITS = aec_pkg::PROB_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [aec_pkg::HIGH_W-1:0]  width_in,
    input  logic [PROB_BITS:0]          factor_in,
    output logic                        done,
    output logic [aec_pkg::HIGH_W-1:0]  product
);

    localparam int STEP_W = $clog2(PROB_BITS + 1);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic [aec_pkg::HIGH_W:0]     acc_reg, acc_next;
    logic [aec_pkg::HIGH_W-1:0]   w_reg, w_next;
    logic [PROB_BITS:0]           f_reg, f_next;
    logic [aec_pkg::HIGH_W:0]     sum;

    // Add the width for a set factor bit, then halve, lowest factor bit first
    always_comb begin
        sum       = acc_reg + (f_reg[0] ? {1'b0, w_reg} : '0);
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        acc_next  = acc_reg;
        w_next    = w_reg;
        f_next    = f_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            acc_next  = '0;
            w_next    = width_in;
            f_next    = factor_in;
        end else if (busy_reg) begin
            if (step_reg == STEP_W'(PROB_BITS)) begin
                acc_next  = sum;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                acc_next  = sum >> 1;
                f_next    = f_reg >> 1;
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        acc_reg  <= acc_next;
        w_reg    <= w_next;
        f_reg    <= f_next;
    end

    assign done    = done_reg;
    assign product = acc_reg[aec_pkg::HIGH_W-1:0];

endmodule

// ===== rtl/aec_rescale.sv =====
// Rescale shifter: one E1/E2 step and one emitted bit per cycle.
`timescale 1ns / 1ps

module aec_rescale (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [aec_pkg::HIGH_W-1:0]  lo_in,
    input  logic [aec_pkg::HIGH_W-1:0]  hi_in,
    output logic                        done,
    output aec_pkg::rescale_res_t       res
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [aec_pkg::HIGH_W-1:0]    lo_reg, lo_next;
    logic [aec_pkg::HIGH_W-1:0]    hi_reg, hi_next;
    logic [aec_pkg::CODE_W-1:0]    code_reg, code_next;
    logic [aec_pkg::COUNT_W-1:0]   count_reg, count_next;

    // Shift out a bit while both ends share a half, stop when full
    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        code_next  = code_reg;
        count_next = count_reg;
        if (start) begin
            busy_next  = 1'b1;
            lo_next    = lo_in;
            hi_next    = hi_in;
            code_next  = '0;
            count_next = '0;
        end else if (busy_reg) begin
            priority if (count_reg == aec_pkg::MAX_OUT_BITS) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else if (hi_reg <= aec_pkg::HALF_INTERVAL) begin
                lo_next    = lo_reg << 1;
                hi_next    = hi_reg << 1;
                code_next  = {code_reg[aec_pkg::CODE_W-2:0], 1'b0};
                count_next = count_reg + 1'b1;
            end else if (lo_reg >= aec_pkg::HALF_INTERVAL) begin
                lo_next    = (lo_reg - aec_pkg::HALF_INTERVAL) << 1;
                hi_next    = (hi_reg - aec_pkg::HALF_INTERVAL) << 1;
                code_next  = {code_reg[aec_pkg::CODE_W-2:0], 1'b1};
                count_next = count_reg + 1'b1;
            end else begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        code_reg  <= code_next;
        count_reg <= count_next;
    end

    assign done      = done_reg;
    assign res.low   = lo_reg[aec_pkg::LOW_W-1:0];
    assign res.high  = hi_reg;
    assign res.code  = code_reg;
    assign res.count = count_reg;

endmodule
